// ===== rtl/core/swdh_pkg.sv =====
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types and constants of the two-wire debug host transfer engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

   // line timing
   localparam int TURNAROUND_CYCLES = 1;
   localparam int LINE_RESET_BYTES  = 10;

   localparam int BIT_INDEX_W = 8;
   localparam int SHIFT_W     = 33;
   localparam int WORD_W      = 32;

   // transaction widths on the streams
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   // sequence lengths in wire clocks
   localparam logic [BIT_INDEX_W-1:0] TA_LEN       = BIT_INDEX_W'(TURNAROUND_CYCLES);
   localparam logic [BIT_INDEX_W-1:0] LR_LEN       = BIT_INDEX_W'(LINE_RESET_BYTES * 8);
   localparam logic [BIT_INDEX_W-1:0] REQ_LEN      = 8'd8;
   localparam logic [BIT_INDEX_W-1:0] ACK_LEN      = 8'd3;
   localparam logic [BIT_INDEX_W-1:0] DATA_LEN     = 8'd33;
   localparam logic [BIT_INDEX_W-1:0] JCMD_LEN     = 8'd16;
   localparam logic [BIT_INDEX_W-1:0] IDLE_LEN     = 8'd4;
   localparam logic [BIT_INDEX_W-1:0] PREAMBLE_LEN = 8'd8;
   localparam logic [BIT_INDEX_W-1:0] ALERT_LEN    = 8'd128;
   localparam logic [BIT_INDEX_W-1:0] ACT_LEN      = 8'd8;

   // fixed bit patterns, sent lsb first
   localparam logic [15:0]  LINE_SELECT_CODE = 16'hE79E;
   localparam logic [7:0]   PREAMBLE         = 8'hFF;
   localparam logic [7:0]   ACTIVATION       = 8'h1A;
   localparam logic [127:0] SEL_ALERT        = {32'h19BC0EA2, 32'hE3DDAFE9,
                                                32'h86852D95, 32'h6209F392};

   // acknowledge codes as sampled
   localparam logic [2:0] ACK_OK    = 3'b001;
   localparam logic [2:0] ACK_WAIT  = 3'b010;
   localparam logic [2:0] ACK_FAULT = 3'b100;

   // reported status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_WAIT      = 3'd1;
   localparam logic [2:0] STAT_FAULT     = 3'd2;
   localparam logic [2:0] STAT_NO_TARGET = 3'd3;
   localparam logic [2:0] STAT_PARITY    = 3'd4;

   typedef enum logic [1:0] {
      ACT_TICK     = 2'd0,
      ACT_TRANSFER = 2'd1,
      ACT_SELECT   = 2'd2,
      ACT_WAKEUP   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_REQ      = 4'd1,
      PH_TURN1    = 4'd2,
      PH_ACK      = 4'd3,
      PH_RDATA    = 4'd4,
      PH_TURN_END = 4'd5,
      PH_TURN2    = 4'd6,
      PH_WDATA    = 4'd7,
      PH_J_LR1    = 4'd8,
      PH_J_CMD    = 4'd9,
      PH_J_LR2    = 4'd10,
      PH_J_IDLE   = 4'd11,
      PH_W_ALERT  = 4'd12,
      PH_W_SEL    = 4'd13,
      PH_W_IDLE   = 4'd14,
      PH_W_ACT    = 4'd15
   } phase_type;

endpackage

// ===== rtl/core/swd_host_transfer_engine.sv =====
// ----------------------------------------------------------------------------
// swd_host_transfer_engine
// Two-wire debug host: request, turnaround, acknowledge and data phases, plus
// the JTAG-to-SWD select and dormant wake-up line sequences.
// ----------------------------------------------------------------------------
// Usage:
//   The req stream carries one transaction per item. tuser selects the kind:
//   a clock tick, or a start of a transfer, a select sequence or a wake-up
//   sequence. A start is taken only when the engine is idle and otherwise
//   ignored; it does not clock the wire. Each tick is one wire clock: it
//   carries the sampled line level and returns the level and drive enable
//   for that clock.
//   The rsp stream returns exactly one transaction per req transaction with
//   line level, drive enable, busy, done, last transfer status and the word
//   of the last good read.
//   rsp_tvalid rises in the cycle after req acceptance; one transaction
//   is taken every cycle while the receiver does not stall, the whole step
//   being one pass through the phase logic into the result register.
//   When the receiver stalls, the result register holds and req_tready
//   drops until that result is taken; a result waiting does not block the
//   next transaction while rsp_tready is high.
//   Reset clears the engine to idle with status ok and read word zero; the
//   rsp stream is empty after reset.
// ----------------------------------------------------------------------------
module swd_host_transfer_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [0] port_is_access, [1] is_read, [3:2] reg_select, [35:4] write_data,
   // [36] line_in, [39:37] zero
   input  logic [swdh_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [swdh_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] line_out, [1] line_drive, [2] busy_res, [3] done_res,
   // [6:4] ack_status, [38:7] read_data, [39] zero
   output logic [swdh_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import swdh_pkg::*;

   // engine state
   phase_type               phase_ff, phase_in;
   logic [BIT_INDEX_W-1:0]  bit_index_ff, bit_index_in;
   logic [SHIFT_W-1:0]      shift_word_ff, shift_word_in;
   logic [2:0]              ack_capture_ff, ack_capture_in;
   logic                    transfer_reads_ff, transfer_reads_in;
   logic [2:0]              status_hold_ff, status_hold_in;
   logic [WORD_W-1:0]       data_hold_ff, data_hold_in;

   // result register
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // unpacked request fields
   action_type              action;
   logic                    port_is_access;
   logic                    is_read;
   logic [1:0]              reg_select;
   logic [WORD_W-1:0]       write_data;
   logic                    line_in;

   logic                    req_accept;
   logic                    line_out;
   logic                    line_drive;
   logic                    done_res;
   logic [BIT_INDEX_W-1:0]  count_next;
   logic [7:0]              request_byte;
   logic                    req_parity;
   logic [WORD_W-1:0]       rd_word;

   assign action         = action_type'(req_tuser[1:0]);
   assign port_is_access = req_tdata[0];
   assign is_read        = req_tdata[1];
   assign reg_select     = req_tdata[3:2];
   assign write_data     = req_tdata[35:4];
   assign line_in        = req_tdata[36];

   // output register frees up when empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // request byte: start, port, read, a2, a3, parity, stop, park
   assign req_parity   = ack_capture_ff[0] ^ transfer_reads_ff ^ ack_capture_ff[1]
                         ^ ack_capture_ff[2];
   assign request_byte = {1'b1, 1'b0, req_parity, ack_capture_ff[2], ack_capture_ff[1],
                          transfer_reads_ff, ack_capture_ff[0], 1'b1};
   assign count_next   = bit_index_ff + 8'd1;
   assign rd_word      = shift_word_ff[WORD_W-1:0];

   // phase logic for one transaction
   always_comb begin
      phase_in          = phase_ff;
      bit_index_in      = bit_index_ff;
      shift_word_in     = shift_word_ff;
      ack_capture_in    = ack_capture_ff;
      transfer_reads_in = transfer_reads_ff;
      status_hold_in    = status_hold_ff;
      data_hold_in      = data_hold_ff;
      line_out          = 1'b0;
      line_drive        = 1'b0;
      done_res          = 1'b0;

      if (action != ACT_TICK) begin
         // starts are taken only when idle
         if (phase_ff == PH_IDLE) begin
            bit_index_in = '0;
            unique case (action)
               ACT_TRANSFER: begin
                  phase_in          = PH_REQ;
                  ack_capture_in    = {reg_select, port_is_access};
                  transfer_reads_in = is_read;
                  shift_word_in     = {^write_data, write_data};
               end
               ACT_SELECT:   phase_in = PH_J_LR1;
               default:      phase_in = PH_W_ALERT;
            endcase
         end
      end else begin
         bit_index_in = count_next;
         unique case (phase_ff)
            PH_IDLE: begin
               bit_index_in = bit_index_ff;
            end
            PH_REQ: begin
               line_drive = 1'b1;
               line_out   = request_byte[bit_index_ff[2:0]];
               if (count_next >= REQ_LEN) begin
                  bit_index_in   = '0;
                  phase_in       = PH_TURN1;
                  ack_capture_in = '0;
               end
            end
            PH_TURN1: begin
               if (count_next >= TA_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_ACK;
               end
            end
            PH_ACK: begin
               if (bit_index_ff[1:0] != 2'd3) begin
                  ack_capture_in[bit_index_ff[1:0]] = ack_capture_ff[bit_index_ff[1:0]]
                                                      | line_in;
               end
               if (count_next >= ACK_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_TURN_END;
                  if (ack_capture_in == ACK_OK) begin
                     if (transfer_reads_ff) begin
                        phase_in      = PH_RDATA;
                        shift_word_in = '0;
                     end else begin
                        phase_in = PH_TURN2;
                     end
                  end
               end
            end
            PH_RDATA: begin
               if (bit_index_ff < DATA_LEN) begin
                  shift_word_in[bit_index_ff[5:0]] = shift_word_ff[bit_index_ff[5:0]]
                                                     | line_in;
               end
               if (count_next >= DATA_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_TURN_END;
               end
            end
            PH_TURN_END: begin
               if (count_next >= TA_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
                  done_res     = 1'b1;
                  unique case (ack_capture_ff)
                     ACK_OK: begin
                        if ((^rd_word) != shift_word_ff[WORD_W]) begin
                           status_hold_in = STAT_PARITY;
                        end else begin
                           status_hold_in = STAT_OK;
                           data_hold_in   = rd_word;
                        end
                     end
                     ACK_WAIT:  status_hold_in = STAT_WAIT;
                     ACK_FAULT: status_hold_in = STAT_FAULT;
                     default:   status_hold_in = STAT_NO_TARGET;
                  endcase
               end
            end
            PH_TURN2: begin
               if (count_next >= TA_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_WDATA;
               end
            end
            PH_WDATA: begin
               line_drive = 1'b1;
               line_out   = (bit_index_ff < DATA_LEN) ? shift_word_ff[bit_index_ff[5:0]]
                                                      : shift_word_ff[0];
               if (count_next >= DATA_LEN) begin
                  bit_index_in   = '0;
                  phase_in       = PH_IDLE;
                  done_res       = 1'b1;
                  status_hold_in = STAT_OK;
               end
            end
            PH_J_LR1: begin
               line_drive = 1'b1;
               line_out   = 1'b1;
               if (count_next >= LR_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_J_CMD;
               end
            end
            PH_J_CMD: begin
               line_drive = 1'b1;
               line_out   = LINE_SELECT_CODE[bit_index_ff[3:0]];
               if (count_next >= JCMD_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_J_LR2;
               end
            end
            PH_J_LR2: begin
               line_drive = 1'b1;
               line_out   = 1'b1;
               if (count_next >= LR_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_J_IDLE;
               end
            end
            PH_J_IDLE: begin
               line_drive = 1'b1;
               if (count_next >= IDLE_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
                  done_res     = 1'b1;
               end
            end
            PH_W_ALERT: begin
               line_drive = 1'b1;
               line_out   = PREAMBLE[bit_index_ff[2:0]];
               if (count_next >= PREAMBLE_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_W_SEL;
               end
            end
            PH_W_SEL: begin
               line_drive = 1'b1;
               line_out   = SEL_ALERT[bit_index_ff[6:0]];
               if (count_next >= ALERT_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_W_IDLE;
               end
            end
            PH_W_IDLE: begin
               line_drive = 1'b1;
               if (count_next >= IDLE_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_W_ACT;
               end
            end
            PH_W_ACT: begin
               line_drive = 1'b1;
               line_out   = ACTIVATION[bit_index_ff[2:0]];
               if (count_next >= ACT_LEN) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
                  done_res     = 1'b1;
               end
            end
            default: begin
               bit_index_in = bit_index_ff;
            end
         endcase
      end

      rsp_data_in = {1'b0, data_hold_in, status_hold_in, done_res,
                     (phase_in != PH_IDLE), line_drive, line_out};
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         bit_index_ff      <= '0;
         shift_word_ff     <= '0;
         ack_capture_ff    <= '0;
         transfer_reads_ff <= 1'b0;
         status_hold_ff    <= STAT_OK;
         data_hold_ff      <= '0;
      end else if (req_accept) begin
         phase_ff          <= phase_in;
         bit_index_ff      <= bit_index_in;
         shift_word_ff     <= shift_word_in;
         ack_capture_ff    <= ack_capture_in;
         transfer_reads_ff <= transfer_reads_in;
         status_hold_ff    <= status_hold_in;
         data_hold_ff      <= data_hold_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a finished operation always reports idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[3] |-> !rsp_data_ff[2])
      else $error("done reported while still busy");

   // a released line is reported low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[1] |-> !rsp_data_ff[0])
      else $error("line level high while released");

   // idle engine keeps its bit counter cleared
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bit_index_ff == '0)
      else $error("bit counter nonzero while idle");

   // every accepted transaction yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   // starts never clock the wire
   assert property (@(posedge clock) disable iff (reset)
      req_accept && action != ACT_TICK |=> !rsp_data_ff[1] && !rsp_data_ff[3])
      else $error("start transaction drove the line or finished");

endmodule

// ===== verif/swd_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_line_checker
// Follows the req and rsp streams of the two-wire debug host, predicts the
// wire clock report for every accepted transaction and compares each returned
// report field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module swd_line_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [0] port_is_access, [1] is_read, [3:2] reg_select, [35:4] write_data,
   // [36] line_in, [39:37] zero
   input  logic [swdh_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [swdh_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] line_out, [1] line_drive, [2] busy_res, [3] done_res,
   // [6:4] ack_status, [38:7] read_data, [39] zero
   input  logic [swdh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              pending
);
   import swdh_pkg::*;

   // wire patterns, sent lsb first
   localparam logic [15:0]  SELECT_CODE     = 16'hE79E;
   localparam logic [7:0]   WAKE_LEAD       = 8'hFF;
   localparam logic [7:0]   ACTIVATION_CODE = 8'h1A;
   localparam logic [127:0] ALERT_PATTERN   = {32'h19BC0EA2, 32'hE3DDAFE9,
                                               32'h86852D95, 32'h6209F392};
   localparam logic [7:0]   TA_BITS         = 8'(TURNAROUND_CYCLES);
   localparam logic [7:0]   LR_BITS         = 8'(LINE_RESET_BYTES * 8);

   // one wire clock report, laid out as on rsp_tdata
   typedef struct packed {
      logic        pad;
      logic [31:0] word;
      logic [2:0]  status;
      logic        done;
      logic        busy;
      logic        drive;
      logic        level;
   } line_report_type;

   // engine state as predicted
   phase_type   phase_q;
   logic [7:0]  bit_cnt;
   logic [32:0] shift_q;
   logic [2:0]  ack_q;
   logic        reads_q;
   logic [2:0]  status_q;
   logic [31:0] word_q;

   line_report_type  report_q[$];
   line_report_type  predicted;
   line_report_type  observed;
   int               errors = 0;

   // count one wire clock of the current phase, move on when it is complete
   function automatic logic advance_bit(input logic [7:0] len, input phase_type follow);
      bit_cnt = bit_cnt + 8'd1;
      if (bit_cnt >= len) begin
         bit_cnt = '0;
         phase_q = follow;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // next report of the engine for one transaction
   task automatic predict_report(input action_type act,
                                 input logic [REQ_DATA_W-1:0] d,
                                 output line_report_type r);
      logic       lo;
      logic       drv;
      logic       fin;
      logic       line;
      logic [7:0] request;
      lo   = 1'b0;
      drv  = 1'b0;
      fin  = 1'b0;
      line = d[36];
      if (act != ACT_TICK) begin
         // starts only land on an idle engine
         if (phase_q == PH_IDLE) begin
            bit_cnt = '0;
            case (act)
               ACT_TRANSFER: begin
                  phase_q = PH_REQ;
                  ack_q   = {d[3], d[2], d[0]};
                  reads_q = d[1];
                  shift_q = {^d[35:4], d[35:4]};
               end
               ACT_SELECT: phase_q = PH_J_LR1;
               default:    phase_q = PH_W_ALERT;
            endcase
         end
      end else begin
         case (phase_q)
            PH_REQ: begin
               // park, stop, parity, a3, a2, read, port, start
               request = {1'b1, 1'b0, ^{ack_q, reads_q}, ack_q[2], ack_q[1],
                          reads_q, ack_q[0], 1'b1};
               drv = 1'b1;
               lo  = request[bit_cnt[2:0]];
               if (advance_bit(8'd8, PH_TURN1))
                  ack_q = '0;
            end
            PH_TURN1: void'(advance_bit(TA_BITS, PH_ACK));
            PH_ACK: begin
               ack_q = ack_q | (3'(line) << bit_cnt[1:0]);
               if (advance_bit(8'd3, PH_TURN_END) && ack_q == ACK_OK) begin
                  if (reads_q) begin
                     phase_q = PH_RDATA;
                     shift_q = '0;
                  end else begin
                     phase_q = PH_TURN2;
                  end
               end
            end
            PH_RDATA: begin
               if (bit_cnt < 8'd33)
                  shift_q[bit_cnt[5:0]] = shift_q[bit_cnt[5:0]] | line;
               void'(advance_bit(8'd33, PH_TURN_END));
            end
            PH_TURN_END: begin
               if (advance_bit(TA_BITS, PH_IDLE)) begin
                  fin = 1'b1;
                  case (ack_q)
                     ACK_OK: begin
                        if (^shift_q[31:0] != shift_q[32]) begin
                           status_q = STAT_PARITY;
                        end else begin
                           status_q = STAT_OK;
                           word_q   = shift_q[31:0];
                        end
                     end
                     ACK_WAIT:  status_q = STAT_WAIT;
                     ACK_FAULT: status_q = STAT_FAULT;
                     default:   status_q = STAT_NO_TARGET;
                  endcase
               end
            end
            PH_TURN2: void'(advance_bit(TA_BITS, PH_WDATA));
            PH_WDATA: begin
               drv = 1'b1;
               lo  = shift_q[(bit_cnt < 8'd33) ? bit_cnt[5:0] : 6'd0];
               if (advance_bit(8'd33, PH_IDLE)) begin
                  fin      = 1'b1;
                  status_q = STAT_OK;
               end
            end
            PH_J_LR1: begin
               drv = 1'b1;
               lo  = 1'b1;
               void'(advance_bit(LR_BITS, PH_J_CMD));
            end
            PH_J_CMD: begin
               drv = 1'b1;
               lo  = SELECT_CODE[bit_cnt[3:0]];
               void'(advance_bit(8'd16, PH_J_LR2));
            end
            PH_J_LR2: begin
               drv = 1'b1;
               lo  = 1'b1;
               void'(advance_bit(LR_BITS, PH_J_IDLE));
            end
            PH_J_IDLE: begin
               drv = 1'b1;
               fin = advance_bit(8'd4, PH_IDLE);
            end
            PH_W_ALERT: begin
               drv = 1'b1;
               lo  = WAKE_LEAD[bit_cnt[2:0]];
               void'(advance_bit(8'd8, PH_W_SEL));
            end
            PH_W_SEL: begin
               drv = 1'b1;
               lo  = ALERT_PATTERN[bit_cnt[6:0]];
               void'(advance_bit(8'd128, PH_W_IDLE));
            end
            PH_W_IDLE: begin
               drv = 1'b1;
               void'(advance_bit(8'd4, PH_W_ACT));
            end
            PH_W_ACT: begin
               drv = 1'b1;
               lo  = ACTIVATION_CODE[bit_cnt[2:0]];
               fin = advance_bit(8'd8, PH_IDLE);
            end
            default: ;
         endcase
      end
      r.pad    = 1'b0;
      r.word   = word_q;
      r.status = status_q;
      r.done   = fin;
      r.busy   = (phase_q != PH_IDLE);
      r.drive  = drv;
      r.level  = lo;
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   // predict on req transactions, compare on rsp transactions
   always @(posedge clock) begin
      if (reset) begin
         phase_q  = PH_IDLE;
         bit_cnt  = '0;
         shift_q  = '0;
         ack_q    = '0;
         reads_q  = 1'b0;
         status_q = STAT_OK;
         word_q   = '0;
         report_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_report(action_type'(req_tuser), req_tdata, predicted);
            report_q.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            observed = rsp_tdata;
            if (report_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               predicted = report_q.pop_front();
               check_field("line_out", 32'(predicted.level), 32'(observed.level));
               check_field("line_drive", 32'(predicted.drive), 32'(observed.drive));
               check_field("busy_res", 32'(predicted.busy), 32'(observed.busy));
               check_field("done_res", 32'(predicted.done), 32'(observed.done));
               check_field("ack_status", 32'(predicted.status), 32'(observed.status));
               check_field("read_data", predicted.word, observed.word);
               check_field("pad", 32'(predicted.pad), 32'(observed.pad));
            end
         end
      end
      pending    <= report_q.size();
      fail_count <= errors;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the two-wire debug host with transfers, select and wake-up sequences
// and stray starts, under changing sender and receiver idling, and gives the
// verdict from the checker's failure count and pending predictions.
// ----------------------------------------------------------------------------
module testbench;
   import swdh_pkg::*;

   localparam int RANDOM_ITEMS    = 1400;
   localparam int STALL_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int SELECT_TICKS    = 2 * LINE_RESET_BYTES * 8 + 16 + 4;
   localparam int WAKEUP_TICKS    = 8 + 128 + 4 + 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    pending;

   int   tx_idle_pct      = 36;
   int   rx_idle_pct      = 77;
   int   stray_start_pct  = 0;
   int   items_sent       = 0;
   logic hold_off_request = 1'b0;

   swd_host_transfer_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swd_line_checker line_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // watchdog on cycles with no transaction on either stream
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   // one req transaction, with random sender gaps ahead of it
   task automatic send_item(input action_type act, input logic [REQ_DATA_W-1:0] d);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic start_op(input action_type act, input logic port, input logic rd,
                           input logic [1:0] sel, input logic [31:0] wdata);
      send_item(act, {3'b000, 1'($urandom), wdata, sel, rd, port});
   endtask

   // one wire clock, sometimes preceded by a random start that the engine ignores unless idle
   task automatic wire_tick(input logic line);
      if ($urandom_range(0, 99) < stray_start_pct)
         start_op(action_type'($urandom_range(1, 3)), 1'($urandom), 1'($urandom),
                  2'($urandom), $urandom);
      send_item(ACT_TICK, {3'b000, line, 32'($urandom), 4'($urandom)});
   endtask

   // full transfer: request, turnaround, acknowledge, then data as the ack allows
   task automatic run_transfer(input logic rd, input logic port, input logic [1:0] sel,
                               input logic [31:0] word, input logic [2:0] ack,
                               input logic bad_par);
      logic [32:0] frame;
      int i;
      frame = {(^word) ^ bad_par, word};
      start_op(ACT_TRANSFER, port, rd, sel, rd ? 32'($urandom) : word);
      for (i = 0; i < 8 + TURNAROUND_CYCLES; i++) wire_tick(1'($urandom));
      for (i = 0; i < 3; i++) wire_tick(ack[i]);
      if (ack == ACK_OK && rd)
         for (i = 0; i < 33; i++) wire_tick(frame[i]);
      for (i = 0; i < TURNAROUND_CYCLES; i++) wire_tick(1'($urandom));
      if (ack == ACK_OK && !rd)
         for (i = 0; i < 33; i++) wire_tick(1'($urandom));
   endtask

   task automatic do_sequence(input action_type act);
      int i;
      start_op(act, 1'($urandom), 1'($urandom), 2'($urandom), $urandom);
      for (i = 0; i < ((act == ACT_SELECT) ? SELECT_TICKS : WAKEUP_TICKS); i++)
         wire_tick(1'($urandom));
   endtask

   // stop sending until every predicted report has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [2:0] random_ack();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return ACK_OK;
      else if (pick == 7)
         return ACK_WAIT;
      else if (pick == 8)
         return ACK_FAULT;
      return 3'($urandom);
   endfunction

   // stimulus
   initial begin
      int p;
      int pick;
      int n;
      int phase_end;
      int base_items;
      int tx_pct[3];
      int rx_pct[3];
      tx_pct = '{36, 77, 0};
      rx_pct = '{77, 36, 0};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_TICK;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: idle line, both directions at the extremes, each ack kind,
      // read parity error, both line sequences, starts while busy
      wire_tick(1'b0);
      wire_tick(1'b1);
      run_transfer(1'b1, 1'b1, 2'b11, 32'hFFFF_FFFF, ACK_OK, 1'b0);
      run_transfer(1'b0, 1'b0, 2'b00, 32'hFFFF_FFFF, ACK_OK, 1'b0);
      run_transfer(1'b0, 1'b1, 2'b01, 32'h0000_0000, ACK_OK, 1'b0);
      run_transfer(1'b1, 1'b0, 2'b01, 32'h0000_0000, ACK_OK, 1'b1);
      run_transfer(1'b0, 1'b1, 2'b10, $urandom, ACK_WAIT, 1'b0);
      run_transfer(1'b1, 1'b1, 2'b01, $urandom, ACK_FAULT, 1'b0);
      run_transfer(1'b1, 1'b0, 2'b10, $urandom, 3'b111, 1'b0);
      run_transfer(1'b0, 1'b0, 2'b11, $urandom, 3'b000, 1'b0);
      do_sequence(ACT_SELECT);
      stray_start_pct = 20;
      do_sequence(ACT_WAKEUP);
      wire_tick(1'b1);

      // random operations over three idling phases
      stray_start_pct = 3;
      base_items = items_sent;
      for (p = 0; p < 3; p++) begin
         if (p != 0)
            wait_drained();
         tx_idle_pct = tx_pct[p];
         rx_idle_pct = rx_pct[p];
         // receiver holds off while the sender keeps offering
         if (p == 2)
            hold_off_request = 1'b1;
         phase_end = base_items + RANDOM_ITEMS * (p + 1) / 3;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
               run_transfer(1'($urandom), 1'($urandom), 2'($urandom), $urandom,
                            random_ack(), ($urandom_range(0, 7) == 0));
            end else if (pick < 88) begin
               do_sequence(ACT_SELECT);
            end else if (pick < 92) begin
               do_sequence(ACT_WAKEUP);
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) wire_tick(1'($urandom));
            end
         end
      end

      // drain and verdict
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
